[hdl/windowed_hamming_match_assert.svh]
// Assertion macros shared by the windowed Hamming matcher RTL.
`ifndef WINDOWED_HAMMING_MATCH_ASSERT_SVH
`define WINDOWED_HAMMING_MATCH_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define WHM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_hamming_match: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define WHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_hamming_match: next-cycle check failed");

`else

`define WHM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WHM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/whm_pkg.sv]
// Types, codes, constants and the popcount function of the windowed Hamming matcher.
package whm_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int COORD_W  = 16;
    localparam int DWORD_W  = 64;
    localparam int QIDX_W   = 10;
    localparam int BIDX_W   = 10;
    localparam int DIST_W   = 9;
    localparam int LIMIT_W  = 8;
    localparam int OPCODE_W = 2;
    localparam int CFGIDX_W = 2;
    localparam int POP_W    = 7;

    // Operation codes of the input channel.
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFGIDX_W-1:0] CFG_WIN_H = 2'd0;
    localparam logic [CFGIDX_W-1:0] CFG_WIN_V = 2'd1;
    localparam logic [CFGIDX_W-1:0] CFG_LIMIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] WIN_H_RESET = 16'd1600;
    localparam logic [COORD_W-1:0] WIN_V_RESET = 16'd320;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

    // Distance reported when no candidate lies inside the window.
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = 9'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Population count of a 64-bit word as a balanced adder tree.
    function automatic logic [POP_W-1:0] pop64(input logic [DWORD_W-1:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        int i;
        for (i = 0; i < 32; i++) begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (i = 0; i < 16; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (i = 0; i < 8; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (i = 0; i < 4; i++) begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (i = 0; i < 2; i++) begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

[hdl/windowed_hamming_match.sv]
// Windowed brute-force Hamming matcher: a query scans every filled entry of the candidate
// table (an empty table goes straight to the result), reading one candidate table entry
// per cycle through a three-stage read/popcount/compare pipe.
// Clear and append transactions leave the sequencer idle; the next item is taken in the
// cycle after a result is loaded, even while that result still waits at the output.
// Reset restores the window and limit registers and empties the table; no RAM clearing.
`include "windowed_hamming_match_assert.svh"

module windowed_hamming_match #(
    parameter int MAX_CANDIDATES = 1024,
    parameter int DESC_BITS      = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Input channel: one transaction carries one clear, append or query command.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [whm_pkg::OPCODE_W-1:0]  opcode,
    input  logic [whm_pkg::COORD_W-1:0]   pos_x,
    input  logic [whm_pkg::COORD_W-1:0]   pos_y,
    input  logic [whm_pkg::DWORD_W-1:0]   desc_word0,
    input  logic [whm_pkg::DWORD_W-1:0]   desc_word1,
    input  logic [whm_pkg::DWORD_W-1:0]   desc_word2,
    input  logic [whm_pkg::DWORD_W-1:0]   desc_word3,

    // Output channel: one transaction per query.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [whm_pkg::QIDX_W-1:0]    query_index,
    output logic                          matched,
    output logic [whm_pkg::BIDX_W-1:0]    best_index,
    output logic [whm_pkg::DIST_W-1:0]    best_distance,

    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [whm_pkg::CFGIDX_W-1:0]  cfg_index,
    input  logic [whm_pkg::DWORD_W-1:0]   cfg_data
);

    import whm_pkg::*;

    // Table index and fill count widths follow the table depth.
    localparam int IDX_W      = $clog2(MAX_CANDIDATES);
    localparam int CNT_W      = $clog2(MAX_CANDIDATES + 1);
    localparam int DESC_WORDS = (DESC_BITS + DWORD_W - 1) / DWORD_W;
    localparam int XOR_W      = DESC_WORDS * DWORD_W;
    localparam int ENTRY_W    = DESC_BITS + 2 * COORD_W;

    // Control state.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cand_cnt_reg, cand_cnt_next;
    logic [QIDX_W-1:0]  qcnt_reg, qcnt_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s2_valid_reg, s2_valid_next;
    logic               out_valid_reg, out_valid_next;

    // Configuration registers.
    logic [COORD_W-1:0] win_h_reg, win_h_next;
    logic [COORD_W-1:0] win_v_reg, win_v_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;

    // Query operands held for the length of the scan.
    logic [COORD_W-1:0]   qx_reg, qx_next;
    logic [COORD_W-1:0]   qy_reg, qy_next;
    logic [DESC_BITS-1:0] qdesc_reg, qdesc_next;

    // Scan pipeline payload and the running best candidate.
    logic [IDX_W-1:0]   s1_idx_reg, s1_idx_next;
    logic [IDX_W-1:0]   s2_idx_reg, s2_idx_next;
    logic               s2_inwin_reg, s2_inwin_next;
    logic [POP_W-1:0]   s2_cnt_reg [DESC_WORDS];
    logic [POP_W-1:0]   s2_cnt_next [DESC_WORDS];
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;

    // Output register payload.
    logic [QIDX_W-1:0]  out_qidx_reg, out_qidx_next;
    logic               out_match_reg, out_match_next;
    logic [BIDX_W-1:0]  out_bidx_reg, out_bidx_next;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;

    // Handshake and sequencing strobes.
    logic in_accept;
    logic cfg_write;
    logic rd_en;
    logic out_load;
    logic last_issue;
    logic table_full;

    // Candidate RAM port signals.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    // Datapath intermediates.
    logic [255:0]         desc_full;
    logic [DESC_BITS-1:0] desc_in;
    logic [XOR_W-1:0]     desc_xor;
    logic [COORD_W-1:0]   cand_x;
    logic [COORD_W-1:0]   cand_y;
    logic [COORD_W-1:0]   dx;
    logic [COORD_W-1:0]   dy;
    logic [DIST_W-1:0]    dist_sum;
    logic                 q_match;

    // Only the low DESC_BITS descriptor bits take part in matching.
    assign desc_full = {desc_word3, desc_word2, desc_word1, desc_word0};
    assign desc_in   = desc_full[DESC_BITS-1:0];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_accept = in_valid && !in_stall;

    // The scan issues its final read when the index reaches the last filled entry.
    assign last_issue = (CNT_W'(scan_idx_reg) == (cand_cnt_reg - CNT_W'(1)));
    assign table_full = (cand_cnt_reg == CNT_W'(MAX_CANDIDATES));

    // Each table entry packs the descriptor with the candidate position above it.
    assign ram_we    = in_accept && (opcode == OP_APPEND) && !table_full;
    assign ram_waddr = cand_cnt_reg[IDX_W-1:0];
    assign ram_wdata = {pos_y, pos_x, desc_in};

    whm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_CANDIDATES)
    ) u_cand_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (rd_en),
        .raddr(scan_idx_reg),
        .rdata(ram_rdata)
    );

    // Sequencer outputs. Items are taken only while idle; the result register
    // loads as soon as it is empty or its current transaction leaves.
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        rd_en    = (state_reg == ST_SCAN);
        out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (opcode == OP_QUERY))
                begin
                    if (cand_cnt_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The best candidate is final once both pipeline stages are empty.
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration, table fill count and query counter.
    always_comb
    begin
        win_h_next    = win_h_reg;
        win_v_next    = win_v_reg;
        limit_next    = limit_reg;
        cand_cnt_next = cand_cnt_reg;
        qcnt_next     = qcnt_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIN_H: win_h_next = cfg_data[COORD_W-1:0];
                CFG_WIN_V: win_v_next = cfg_data[COORD_W-1:0];
                CFG_LIMIT: limit_next = cfg_data[LIMIT_W-1:0];
                default:   ;
            endcase
        end

        if (in_accept && (opcode == OP_CLEAR))
        begin
            cand_cnt_next = '0;
            qcnt_next     = '0;
        end
        else if (ram_we)
        begin
            cand_cnt_next = cand_cnt_reg + CNT_W'(1);
        end

        // The counter wraps naturally at its ten-bit width.
        if (out_load)
        begin
            qcnt_next = qcnt_reg + QIDX_W'(1);
        end
    end

    // Query capture and scan address.
    always_comb
    begin
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        qdesc_next    = qdesc_reg;
        scan_idx_next = scan_idx_reg;

        if (in_accept && (opcode == OP_QUERY))
        begin
            qx_next       = pos_x;
            qy_next       = pos_y;
            qdesc_next    = desc_in;
            scan_idx_next = '0;
        end
        else if (rd_en && !last_issue)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end
    end

    // Stage one is the RAM read; stage two forms the window test and the
    // per-word popcounts of the descriptor difference.
    always_comb
    begin
        s1_valid_next = rd_en;
        s1_idx_next   = scan_idx_reg;

        cand_x   = ram_rdata[DESC_BITS +: COORD_W];
        cand_y   = ram_rdata[DESC_BITS + COORD_W +: COORD_W];
        desc_xor = XOR_W'(ram_rdata[DESC_BITS-1:0] ^ qdesc_reg);
        dx       = (qx_reg >= cand_x) ? (qx_reg - cand_x) : (cand_x - qx_reg);
        dy       = (qy_reg >= cand_y) ? (qy_reg - cand_y) : (cand_y - qy_reg);

        s2_valid_next = s1_valid_reg;
        s2_idx_next   = s1_idx_reg;
        s2_inwin_next = (dx <= win_h_reg) && (dy <= win_v_reg);
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            s2_cnt_next[w] = pop64(desc_xor[w*DWORD_W +: DWORD_W]);
        end
    end

    // Stage three totals the distance and keeps the first strictly smaller one.
    always_comb
    begin
        dist_sum = '0;
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            dist_sum = dist_sum + DIST_W'(s2_cnt_reg[w]);
        end

        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (in_accept && (opcode == OP_QUERY))
        begin
            best_dist_next = NO_MATCH_DIST;
            best_idx_next  = '0;
        end
        else if (s2_valid_reg && s2_inwin_reg && (dist_sum < best_dist_reg))
        begin
            best_dist_next = dist_sum;
            best_idx_next  = s2_idx_reg;
        end
    end

    // Result register. A limit of at most 255 also rules out the empty window.
    always_comb
    begin
        q_match        = (best_dist_reg <= DIST_W'(limit_reg));
        out_valid_next = out_valid_reg;
        out_qidx_next  = out_qidx_reg;
        out_match_next = out_match_reg;
        out_bidx_next  = out_bidx_reg;
        out_dist_next  = out_dist_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_qidx_next  = qcnt_reg;
            out_match_next = q_match;
            out_bidx_next  = q_match ? BIDX_W'(best_idx_reg) : '0;
            out_dist_next  = best_dist_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cand_cnt_reg  <= '0;
            qcnt_reg      <= '0;
            scan_idx_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_h_reg     <= WIN_H_RESET;
            win_v_reg     <= WIN_V_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cand_cnt_reg  <= cand_cnt_next;
            qcnt_reg      <= qcnt_next;
            scan_idx_reg  <= scan_idx_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            win_h_reg     <= win_h_next;
            win_v_reg     <= win_v_next;
            limit_reg     <= limit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        qdesc_reg     <= qdesc_next;
        s1_idx_reg    <= s1_idx_next;
        s2_idx_reg    <= s2_idx_next;
        s2_inwin_reg  <= s2_inwin_next;
        s2_cnt_reg    <= s2_cnt_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        out_qidx_reg  <= out_qidx_next;
        out_match_reg <= out_match_next;
        out_bidx_reg  <= out_bidx_next;
        out_dist_reg  <= out_dist_next;
    end

    assign out_valid     = out_valid_reg;
    assign query_index   = out_qidx_reg;
    assign matched       = out_match_reg;
    assign best_index    = out_bidx_reg;
    assign best_distance = out_dist_reg;

    // The scan never addresses an entry at or beyond the fill count.
    `WHM_ASSERT_IMPLY(a_scan_in_table, clk, rst_n, state_reg == ST_SCAN,
        CNT_W'(scan_idx_reg) < cand_cnt_reg)

    // The result is taken only after the compare pipeline has drained.
    `WHM_ASSERT_IMPLY(a_finish_drained, clk, rst_n, state_reg == ST_FINISH,
        !s1_valid_reg && !s2_valid_reg)

    // A reported match lies within the limit; a miss carries index zero.
    `WHM_ASSERT_IMPLY(a_match_consistent, clk, rst_n, out_valid_reg,
        (matched && (best_distance <= DIST_W'(limit_reg))) || (!matched && (best_index == '0)))

    // An accepted query always leaves the idle state for a scan or a result.
    `WHM_ASSERT_NEXT(a_query_starts, clk, rst_n, in_accept && (opcode == OP_QUERY),
        state_reg != ST_IDLE)

endmodule

[hdl/whm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module whm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
